@@ rtl/core/nsfc_pkg.sv @@
// Shared constants, types and helper functions of the NMEA sentence framer and checker.
package nsfc_pkg;

  localparam int MAX_LINE  = 128;
  localparam int IDX_W     = $clog2(MAX_LINE);
  localparam int LEN_W     = $clog2(MAX_LINE + 1);
  localparam int BANK_W    = 2;
  localparam int ADDR_W    = BANK_W + IDX_W;
  localparam int RAM_DEPTH = 1 << ADDR_W;

  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_STAR    = 8'h2A;

  localparam int MIN_LINE   = 6;
  localparam int HEADER_LEN = 6;

  localparam logic [2:0] VERDICT_NONE   = 3'd0;
  localparam logic [2:0] VERDICT_REJECT = 3'd1;
  localparam logic [2:0] VERDICT_OTHER  = 3'd2;
  localparam logic [2:0] VERDICT_GGA    = 3'd3;
  localparam logic [2:0] VERDICT_RMC    = 3'd4;

  localparam logic KIND_GGA = 1'b0;
  localparam logic KIND_RMC = 1'b1;

  // Result fields of one transaction, before the output register.
  typedef struct packed {
    logic [2:0] verdict;
    logic       overflowed;
    logic       byte_valid;
    logic [7:0] length;
  } result_t;

  // Access to the sentence memory for one transaction.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  // Expected header character at positions 1 to 5 of a GGA or RMC sentence.
  function automatic logic [7:0] header_char(input logic kind, input logic [2:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    case (pos)
      3'd1: ch = 8'h47;
      3'd2: ch = 8'h4E;
      3'd3: ch = (kind == KIND_RMC) ? 8'h52 : 8'h47;
      3'd4: ch = (kind == KIND_RMC) ? 8'h4D : 8'h47;
      3'd5: ch = (kind == KIND_RMC) ? 8'h43 : 8'h41;
      default: ch = CH_DOLLAR;
    endcase
    return ch;
  endfunction

  // Hex digit decode: bit 4 flags a legal digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      v = {1'b1, 4'(c - 8'h30)};
    end else if (c inside {[8'h41:8'h46]}) begin
      v = {1'b1, 4'(c - 8'h37)};
    end else if (c inside {[8'h61:8'h66]}) begin
      v = {1'b1, 4'(c - 8'h57)};
    end
    return v;
  endfunction

endpackage

@@ rtl/core/nsfc_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module nsfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/nsfc_tracker.sv @@
// Line tracker: incremental checksum, header and star tracking plus bank pointers.
module nsfc_tracker (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    take,
  input  logic                    mode,
  input  logic [7:0]              rx_byte,
  input  logic                    read_kind,
  input  logic [6:0]              read_index,
  output nsfc_pkg::result_t       result,
  output nsfc_pkg::ram_req_t      ram_req
);

  logic [nsfc_pkg::LEN_W-1:0]  line_length, line_length_next;
  logic                        overflow, overflow_next;
  logic [7:0]                  running_xor, running_xor_next;
  logic                        star_seen, star_seen_next;
  logic [1:0]                  after_count, after_count_next;
  logic [7:0]                  hex_hi, hex_hi_next;
  logic [7:0]                  hex_lo, hex_lo_next;
  logic                        first_dollar, first_dollar_next;
  logic                        gga_ok, gga_ok_next;
  logic                        rmc_ok, rmc_ok_next;
  logic [nsfc_pkg::BANK_W-1:0] cur_bank, cur_bank_next;
  logic [nsfc_pkg::BANK_W-1:0] gga_bank, gga_bank_next;
  logic [nsfc_pkg::BANK_W-1:0] rmc_bank, rmc_bank_next;
  logic [nsfc_pkg::LEN_W-1:0]  gga_length, gga_length_next;
  logic [nsfc_pkg::LEN_W-1:0]  rmc_length, rmc_length_next;

  logic [nsfc_pkg::BANK_W-1:0] sel_bank;
  logic [nsfc_pkg::LEN_W-1:0]  sel_length;
  logic [4:0]                  hi_dec, lo_dec;
  logic                        line_good;
  logic [2:0]                  hdr_pos;

  assign sel_bank   = (read_kind == nsfc_pkg::KIND_RMC) ? rmc_bank : gga_bank;
  assign sel_length = (read_kind == nsfc_pkg::KIND_RMC) ? rmc_length : gga_length;
  assign hi_dec     = nsfc_pkg::hex_value(hex_hi);
  assign lo_dec     = nsfc_pkg::hex_value(hex_lo);
  assign hdr_pos    = (line_length < nsfc_pkg::LEN_W'(nsfc_pkg::HEADER_LEN))
                      ? 3'(line_length) : 3'd0;

  // The whole line check reduces to registered flags, so no memory read is needed.
  assign line_good = !overflow && first_dollar && star_seen && (after_count == 2'd2)
                     && (line_length >= nsfc_pkg::LEN_W'(nsfc_pkg::MIN_LINE))
                     && hi_dec[4] && lo_dec[4] && (running_xor == {hi_dec[3:0], lo_dec[3:0]});

  always_comb begin
    line_length_next  = line_length;
    overflow_next     = overflow;
    running_xor_next  = running_xor;
    star_seen_next    = star_seen;
    after_count_next  = after_count;
    hex_hi_next       = hex_hi;
    hex_lo_next       = hex_lo;
    first_dollar_next = first_dollar;
    gga_ok_next       = gga_ok;
    rmc_ok_next       = rmc_ok;
    cur_bank_next     = cur_bank;
    gga_bank_next     = gga_bank;
    rmc_bank_next     = rmc_bank;
    gga_length_next   = gga_length;
    rmc_length_next   = rmc_length;
    result            = '0;
    ram_req           = '0;
    ram_req.wdata     = rx_byte;
    ram_req.waddr     = {cur_bank, nsfc_pkg::IDX_W'(line_length)};
    ram_req.raddr     = {sel_bank, nsfc_pkg::IDX_W'(read_index)};

    if (take) begin
      if (mode) begin
        ram_req.re        = 1'b1;
        result.byte_valid = (nsfc_pkg::LEN_W'(read_index) < sel_length);
        result.length     = 8'(sel_length);
      end else if (rx_byte == nsfc_pkg::CH_DOLLAR) begin
        ram_req.we        = 1'b1;
        ram_req.waddr     = {cur_bank, nsfc_pkg::IDX_W'(0)};
        line_length_next  = nsfc_pkg::LEN_W'(1);
        overflow_next     = 1'b0;
        running_xor_next  = 8'h00;
        star_seen_next    = 1'b0;
        after_count_next  = 2'd0;
        first_dollar_next = 1'b1;
        gga_ok_next       = 1'b1;
        rmc_ok_next       = 1'b1;
      end else if (rx_byte == nsfc_pkg::CH_NEWLINE) begin
        result.overflowed = overflow;
        result.verdict    = nsfc_pkg::VERDICT_REJECT;
        if (line_good) begin
          if (gga_ok) begin
            result.verdict  = nsfc_pkg::VERDICT_GGA;
            gga_bank_next   = cur_bank;
            cur_bank_next   = gga_bank;
            gga_length_next = line_length;
          end else if (rmc_ok) begin
            result.verdict  = nsfc_pkg::VERDICT_RMC;
            rmc_bank_next   = cur_bank;
            cur_bank_next   = rmc_bank;
            rmc_length_next = line_length;
          end else begin
            result.verdict  = nsfc_pkg::VERDICT_OTHER;
          end
        end
        line_length_next  = '0;
        overflow_next     = 1'b0;
        running_xor_next  = 8'h00;
        star_seen_next    = 1'b0;
        after_count_next  = 2'd0;
        first_dollar_next = 1'b0;
        gga_ok_next       = 1'b0;
        rmc_ok_next       = 1'b0;
      end else if (line_length >= nsfc_pkg::LEN_W'(nsfc_pkg::MAX_LINE)) begin
        overflow_next = 1'b1;
      end else begin
        ram_req.we       = 1'b1;
        line_length_next = line_length + nsfc_pkg::LEN_W'(1);
        if (!star_seen) begin
          if (rx_byte == nsfc_pkg::CH_STAR) begin
            star_seen_next = 1'b1;
          end else if (line_length != '0) begin
            running_xor_next = running_xor ^ rx_byte;
          end
        end else begin
          if (after_count == 2'd0) begin
            hex_hi_next      = rx_byte;
            after_count_next = 2'd1;
          end else if (after_count == 2'd1) begin
            hex_lo_next      = rx_byte;
            after_count_next = 2'd2;
          end
        end
        if (hdr_pos != 3'd0) begin
          gga_ok_next = gga_ok && (rx_byte == nsfc_pkg::header_char(nsfc_pkg::KIND_GGA, hdr_pos));
          rmc_ok_next = rmc_ok && (rx_byte == nsfc_pkg::header_char(nsfc_pkg::KIND_RMC, hdr_pos));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length  <= '0;
      overflow     <= 1'b0;
      running_xor  <= 8'h00;
      star_seen    <= 1'b0;
      after_count  <= 2'd0;
      first_dollar <= 1'b0;
      gga_ok       <= 1'b0;
      rmc_ok       <= 1'b0;
      cur_bank     <= nsfc_pkg::BANK_W'(0);
      gga_bank     <= nsfc_pkg::BANK_W'(1);
      rmc_bank     <= nsfc_pkg::BANK_W'(2);
      gga_length   <= '0;
      rmc_length   <= '0;
    end else begin
      line_length  <= line_length_next;
      overflow     <= overflow_next;
      running_xor  <= running_xor_next;
      star_seen    <= star_seen_next;
      after_count  <= after_count_next;
      first_dollar <= first_dollar_next;
      gga_ok       <= gga_ok_next;
      rmc_ok       <= rmc_ok_next;
      cur_bank     <= cur_bank_next;
      gga_bank     <= gga_bank_next;
      rmc_bank     <= rmc_bank_next;
      gga_length   <= gga_length_next;
      rmc_length   <= rmc_length_next;
    end
  end

  always_ff @(posedge clk) begin
    hex_hi <= hex_hi_next;
    hex_lo <= hex_lo_next;
  end

`ifndef SYNTH
  // The line being built and the two stored sentences must always sit in separate banks.
  a_banks_distinct: assert property (@(posedge clk) disable iff (rst)
    (cur_bank != gga_bank) && (cur_bank != rmc_bank) && (gga_bank != rmc_bank))
    else $error("sentence banks overlap");

  // A write into the memory never targets a bank that holds a stored sentence.
  a_write_own_bank: assert property (@(posedge clk) disable iff (rst)
    ram_req.we |-> (ram_req.waddr[nsfc_pkg::ADDR_W-1:nsfc_pkg::IDX_W] == cur_bank))
    else $error("write outside the current line bank");
`endif

endmodule

@@ rtl/core/nmea_sentence_framer_checker.sv @@
// Top level of the NMEA 0183 sentence framer and checksum checker.
// The result of an accepted transaction is registered in the output register.
// Throughput: one transaction per cycle; a stalled result holds the input side.
// Stored sentences live in banks of one memory; a stored kind is replaced by a pointer swap.
// Reset is synchronous and clears all control state and lengths; memory is not cleared.
// Reads are gated by stored lengths, so no clearing pass is needed after reset.
module nmea_sentence_framer_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic       mode,
  input  logic [7:0] rx_byte,
  input  logic       read_kind,
  input  logic [6:0] read_index,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [2:0] line_verdict,
  output logic       line_overflowed,
  output logic [7:0] read_byte,
  output logic [7:0] read_length
);

  // A transaction is taken whenever the output register is free or being emptied.
  logic                 take;
  nsfc_pkg::result_t    result;
  nsfc_pkg::ram_req_t   ram_req;
  nsfc_pkg::result_t    result_reg;
  logic [7:0]           ram_rdata;

  assign item_stall = result_valid && result_stall;
  assign take       = item_valid && !item_stall;

  // The tracker holds every per-line flag, so a line end is judged without a memory read.
  nsfc_tracker u_tracker (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .mode       (mode),
    .rx_byte    (rx_byte),
    .read_kind  (read_kind),
    .read_index (read_index),
    .result     (result),
    .ram_req    (ram_req)
  );

  // Line bytes are written into the current bank; reads of stored sentences come back
  // registered alongside the rest of the result. The read register only moves on a read
  // transaction, so it holds steady while a result is stalled.
  nsfc_ram #(
    .WIDTH (8),
    .DEPTH (nsfc_pkg::RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (!item_stall) begin
      result_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result_reg <= result;
    end
  end

  assign line_verdict    = result_reg.verdict;
  assign line_overflowed = result_reg.overflowed;
  assign read_length     = result_reg.length;
  assign read_byte       = result_reg.byte_valid ? ram_rdata : 8'h00;

`ifndef SYNTH
  // A line-end result never carries read data.
  a_verdict_no_read: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (line_verdict != nsfc_pkg::VERDICT_NONE))
      |-> ((read_length == 8'h00) && (read_byte == 8'h00)))
    else $error("line verdict combined with read data");

  // An overflowed line is always rejected.
  a_overflow_rejected: assert property (@(posedge clk) disable iff (rst)
    (result_valid && line_overflowed) |-> (line_verdict == nsfc_pkg::VERDICT_REJECT))
    else $error("overflowed line not rejected");
`endif

endmodule

@@ tb/nmea_sentence_framer_checker_test.sv @@
// Self-checking testbench of the NMEA sentence framer and checksum checker.
module nmea_sentence_framer_checker_test;
  import nsfc_pkg::*;

  // Number of random transactions to queue after the directed opening.
  localparam int RANDOM_ITEMS = 1350;
  // Cycles without any accepted transaction on either side before the run is abandoned.
  localparam int QUIET_LIMIT = 2000;
  // Cycles allowed after the last expected result, so that a stray extra result is caught.
  localparam int DRAIN_CYCLES = 8;

  // The two header strings that cause a sentence to be kept.
  localparam string GGA_HEADER = "$GNGGA";
  localparam string RMC_HEADER = "$GNRMC";

  // One input transaction as the sender presents it.
  typedef struct {
    logic       mode;
    logic [7:0] rx;
    logic       kind;
    logic [6:0] idx;
  } frame_txn_t;

  // One result transaction as the block should return it.
  typedef struct packed {
    logic [2:0] verdict;
    logic       overflowed;
    logic [7:0] byte_out;
    logic [7:0] length_out;
  } frame_outcome_t;

  // Header families that the sentence generator can produce.
  typedef enum int {
    TAG_GGA,
    TAG_RMC,
    TAG_OTHER,
    TAG_NEAR
  } header_e;

  // Ways in which a generated sentence can be spoilt.
  typedef enum int {
    FLAW_NONE,
    FLAW_BAD_SUM,
    FLAW_NO_STAR,
    FLAW_BAD_HEX,
    FLAW_NO_DOLLAR,
    FLAW_ONE_DIGIT,
    FLAW_STRAY_DOLLAR,
    FLAW_EXTRA_STAR
  } flaw_e;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       item_valid = 1'b0;
  logic       item_stall;
  logic       mode = 1'b0;
  logic [7:0] rx_byte = 8'h00;
  logic       read_kind = 1'b0;
  logic [6:0] read_index = 7'd0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  logic [2:0] line_verdict;
  logic       line_overflowed;
  logic [7:0] read_byte;
  logic [7:0] read_length;

  frame_txn_t     queued_transactions[$];
  frame_outcome_t awaited_outcomes[$];
  int             planned_items = 0;
  int             items_accepted = 0;
  int             quiet_cycles = 0;
  int             failures = 0;

  // Predictor state: the line being assembled and the two kept sentences.
  logic [7:0]  cur_line[MAX_LINE];
  int unsigned cur_len = 0;
  bit          cur_ovf = 1'b0;
  logic [7:0]  cur_xor = 8'h00;
  bit          star_found = 1'b0;
  int unsigned star_at = 0;
  logic [7:0]  gga_copy[MAX_LINE];
  int unsigned gga_len = 0;
  logic [7:0]  rmc_copy[MAX_LINE];
  int unsigned rmc_len = 0;

  nmea_sentence_framer_checker u_top (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item_stall      (item_stall),
    .mode            (mode),
    .rx_byte         (rx_byte),
    .read_kind       (read_kind),
    .read_index      (read_index),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .line_verdict    (line_verdict),
    .line_overflowed (line_overflowed),
    .read_byte       (read_byte),
    .read_length     (read_length)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Value of an ASCII hex digit, either case, or -1 when the byte is not a digit.
  function automatic int hex_nibble(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
    return -1;
  endfunction

  // Forget the line in progress, as at a newline or before a fresh '$'.
  function automatic void restart_line();
    cur_len    = 0;
    cur_ovf    = 1'b0;
    cur_xor    = 8'h00;
    star_found = 1'b0;
    star_at    = 0;
  endfunction

  function automatic bit line_has_header(string tag);
    for (int i = 0; i < HEADER_LEN; i++) begin
      if (cur_line[i] != 8'(tag[i])) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Advances the predictor by one accepted transaction and returns the result it must cause.
  function automatic frame_outcome_t frame_and_check(logic md, logic [7:0] c, logic knd,
                                                     logic [6:0] idx);
    frame_outcome_t o;
    int hi;
    int lo;
    bit ok;
    o = '0;
    if (md) begin
      // A read of a kept sentence: bytes past its length come back as zero.
      if (knd == KIND_RMC) begin
        if (idx < rmc_len) o.byte_out = rmc_copy[idx];
        o.length_out = 8'(rmc_len);
      end else begin
        if (idx < gga_len) o.byte_out = gga_copy[idx];
        o.length_out = 8'(gga_len);
      end
      return o;
    end
    if (c == CH_DOLLAR) begin
      restart_line();
      cur_line[0] = CH_DOLLAR;
      cur_len = 1;
    end else if (c == CH_NEWLINE) begin
      o.overflowed = cur_ovf;
      o.verdict = VERDICT_REJECT;
      ok = !cur_ovf && cur_len >= MIN_LINE && cur_line[0] == CH_DOLLAR && star_found &&
           star_at + 2 < cur_len;
      if (ok) begin
        hi = hex_nibble(cur_line[star_at + 1]);
        lo = hex_nibble(cur_line[star_at + 2]);
        ok = hi >= 0 && lo >= 0 && cur_xor == 8'((hi << 4) | lo);
      end
      if (ok) begin
        if (line_has_header(GGA_HEADER)) begin
          for (int i = 0; i < cur_len; i++) gga_copy[i] = cur_line[i];
          gga_len = cur_len;
          o.verdict = VERDICT_GGA;
        end else if (line_has_header(RMC_HEADER)) begin
          for (int i = 0; i < cur_len; i++) rmc_copy[i] = cur_line[i];
          rmc_len = cur_len;
          o.verdict = VERDICT_RMC;
        end else begin
          o.verdict = VERDICT_OTHER;
        end
      end
      restart_line();
    end else if (cur_len >= MAX_LINE) begin
      // A full line drops the byte and remembers that it overflowed.
      cur_ovf = 1'b1;
    end else begin
      if (!star_found) begin
        if (c == CH_STAR) begin
          star_found = 1'b1;
          star_at = cur_len;
        end else if (cur_len >= 1) begin
          cur_xor ^= c;
        end
      end
      cur_line[cur_len] = c;
      cur_len++;
    end
    return o;
  endfunction

  task automatic push_rx(logic [7:0] c);
    queued_transactions.push_back('{mode: 1'b0, rx: c, kind: 1'($urandom),
                                    idx: 7'($urandom)});
  endtask

  task automatic push_read(logic knd, logic [6:0] idx);
    queued_transactions.push_back('{mode: 1'b1, rx: 8'($urandom), kind: knd, idx: idx});
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] n, bit lower);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return (lower ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
  endfunction

  // A character that may stand in a sentence body: never '$', '*' or a newline.
  function automatic logic [7:0] body_char();
    logic [7:0] c;
    do begin
      if ($urandom_range(7) == 0) c = 8'($urandom);
      else c = 8'($urandom_range(32, 126));
    end while (c == CH_DOLLAR || c == CH_STAR || c == CH_NEWLINE);
    return c;
  endfunction

  function automatic logic [7:0] upper_letter();
    return 8'($urandom_range(65, 90));
  endfunction

  // Queues one sentence, from its '$' to its newline, spoilt as the flaw asks.
  task automatic add_sentence(header_e tag, int body_len, flaw_e flaw, bit with_cr);
    logic [7:0] line_bytes[$];
    string      head;
    logic [7:0] sum;
    logic [7:0] ch;
    int         pos;
    case (tag)
      TAG_GGA: head = GGA_HEADER;
      TAG_RMC: head = RMC_HEADER;
      TAG_OTHER: begin
        head = "$GPxxx";
        for (int i = 3; i < HEADER_LEN; i++) head[i] = upper_letter();
      end
      default: begin
        // Differs from a kept header in exactly one letter.
        head = $urandom_range(1) ? GGA_HEADER : RMC_HEADER;
        pos = $urandom_range(1, HEADER_LEN - 1);
        do ch = upper_letter(); while (ch == 8'(head[pos]));
        head[pos] = ch;
      end
    endcase
    for (int i = 0; i < HEADER_LEN; i++) line_bytes.push_back(8'(head[i]));
    for (int i = 0; i < body_len; i++) line_bytes.push_back(body_char());
    sum = 8'h00;
    for (int i = 1; i < line_bytes.size(); i++) sum ^= line_bytes[i];
    if (flaw == FLAW_BAD_SUM) sum ^= 8'($urandom_range(1, 255));
    if (flaw == FLAW_EXTRA_STAR) begin
      line_bytes.insert($urandom_range(1, line_bytes.size()), CH_STAR);
    end
    if (flaw == FLAW_STRAY_DOLLAR) begin
      line_bytes.insert($urandom_range(1, line_bytes.size()), CH_DOLLAR);
    end
    if (flaw != FLAW_NO_STAR) line_bytes.push_back(CH_STAR);
    if (flaw == FLAW_BAD_HEX) begin
      do ch = 8'($urandom_range(33, 126));
      while (hex_nibble(ch) >= 0 || ch == CH_DOLLAR || ch == CH_STAR);
      line_bytes.push_back(ch);
    end else begin
      line_bytes.push_back(hex_char(sum[7:4], 1'($urandom)));
    end
    if (flaw != FLAW_ONE_DIGIT) line_bytes.push_back(hex_char(sum[3:0], 1'($urandom)));
    if (flaw == FLAW_NO_DOLLAR) line_bytes[0] = body_char();
    if (with_cr) line_bytes.push_back(8'h0D);
    line_bytes.push_back(CH_NEWLINE);
    foreach (line_bytes[i]) push_rx(line_bytes[i]);
  endtask

  function automatic header_e random_header();
    int pick;
    pick = $urandom_range(99);
    if (pick < 35) return TAG_GGA;
    if (pick < 70) return TAG_RMC;
    if (pick < 90) return TAG_OTHER;
    return TAG_NEAR;
  endfunction

  // The run falls into three equal parts by accepted transactions: a lightly idling sender
  // against a heavily stalling receiver, then the reverse, then neither side idles.
  function automatic int sender_idle_pct();
    if (items_accepted < planned_items / 3) return 6;
    if (items_accepted < 2 * planned_items / 3) return 65;
    return 0;
  endfunction

  function automatic int receiver_stall_pct();
    if (items_accepted < planned_items / 3) return 65;
    if (items_accepted < 2 * planned_items / 3) return 6;
    return 0;
  endfunction

  // Driver. An accepted transaction is passed through the predictor at the very edge that
  // accepts it, so the store of awaited results is always in acceptance order. A payload that
  // is stalled is held unchanged; otherwise the next queued transaction is offered, unless the
  // sender chooses to idle this cycle.
  always @(posedge clk) begin : drive_items
    frame_txn_t nxt;
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        awaited_outcomes.push_back(frame_and_check(mode, rx_byte, read_kind, read_index));
        items_accepted++;
      end
      if (!item_valid || !item_stall) begin
        if (queued_transactions.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
          nxt = queued_transactions.pop_front();
          item_valid <= 1'b1;
          mode       <= nxt.mode;
          rx_byte    <= nxt.rx;
          read_kind  <= nxt.kind;
          read_index <= nxt.idx;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor. Every accepted result is compared field by field with the oldest awaited one;
  // a result that arrives with nothing awaited is itself a failure. The stall towards the
  // block is redrawn every cycle.
  always @(posedge clk) begin : watch_results
    frame_outcome_t exp_o;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (awaited_outcomes.size() == 0) begin
          $error("result transaction arrived with none awaited");
          failures++;
        end else begin
          exp_o = awaited_outcomes.pop_front();
          if (line_verdict !== exp_o.verdict) begin
            $error("line_verdict expected %0d actual %0d", exp_o.verdict, line_verdict);
            failures++;
          end
          if (line_overflowed !== exp_o.overflowed) begin
            $error("line_overflowed expected %0d actual %0d", exp_o.overflowed,
                   line_overflowed);
            failures++;
          end
          if (read_byte !== exp_o.byte_out) begin
            $error("read_byte expected %0d actual %0d", exp_o.byte_out, read_byte);
            failures++;
          end
          if (read_length !== exp_o.length_out) begin
            $error("read_length expected %0d actual %0d", exp_o.length_out, read_length);
            failures++;
          end
        end
      end
      result_stall <= ($urandom_range(99) < receiver_stall_pct());
    end
  end

  // Watchdog: a long spell with no transaction accepted on either side means the block has
  // hung, or a result that is awaited will never come.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("nmea_sentence_framer_checker_test NOT OK");
      $finish;
    end
  end

  initial begin : run_test
    int target;
    int pick;
    int burst;
    // Directed opening. Reads before anything is kept must report zero length, bytes on a
    // line that never saw a '$' are collected and then rejected, as is an empty line, and a
    // minimal well-formed GGA sentence is kept and read back, including past its end.
    push_read(KIND_GGA, 7'd0);
    push_read(KIND_RMC, 7'd127);
    push_rx(8'h00);
    push_rx(8'hFF);
    push_rx(CH_NEWLINE);
    push_rx(CH_NEWLINE);
    add_sentence(TAG_GGA, 0, FLAW_NONE, 1'b0);
    push_read(KIND_GGA, 7'd0);
    push_read(KIND_GGA, 7'd127);
    push_read(KIND_RMC, 7'd0);

    // A kept sentence of the greatest length the line can hold, read at both ends; then a
    // line one byte too long, which must be rejected as overflowed and leave GGA untouched.
    add_sentence(TAG_RMC, MAX_LINE - HEADER_LEN - 3, FLAW_NONE, 1'b0);
    push_read(KIND_RMC, 7'd127);
    push_read(KIND_RMC, 7'd0);
    add_sentence(TAG_GGA, MAX_LINE - HEADER_LEN - 2, FLAW_NONE, 1'b0);
    push_read(KIND_GGA, 7'd5);

    // Random part: mostly well-formed sentences with random content, some spoilt ones,
    // bursts of reads, raw noise and now and then a line near or past the length limit.
    target = queued_transactions.size() + RANDOM_ITEMS;
    while (queued_transactions.size() < target) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        add_sentence(random_header(), $urandom_range(0, 24), FLAW_NONE, 1'($urandom));
      end else if (pick < 72) begin
        add_sentence(random_header(), $urandom_range(0, 24), flaw_e'($urandom_range(1, 7)),
                     1'($urandom));
      end else if (pick < 88) begin
        burst = $urandom_range(1, 6);
        repeat (burst) begin
          push_read(1'($urandom),
                    $urandom_range(2) == 0 ? 7'($urandom) : 7'($urandom_range(0, 15)));
        end
      end else if (pick < 98) begin
        burst = $urandom_range(1, 8);
        repeat (burst) push_rx(8'($urandom));
      end else begin
        add_sentence(random_header(), $urandom_range(MAX_LINE - 18, MAX_LINE + 2), FLAW_NONE,
                     1'b0);
      end
    end
    planned_items = queued_transactions.size();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Sample the drain condition away from the rising edge, where the driver and the
    // monitor update the queues.
    @(negedge clk);
    while (queued_transactions.size() != 0 || item_valid || awaited_outcomes.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (failures == 0) begin
      $display("nmea_sentence_framer_checker_test OK");
    end else begin
      $display("nmea_sentence_framer_checker_test NOT OK");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/nsfc_pkg.sv
rtl/core/nsfc_ram.sv
rtl/core/nsfc_tracker.sv
rtl/core/nmea_sentence_framer_checker.sv
tb/nmea_sentence_framer_checker_test.sv
